[src/fsa_pkg.sv]
package fsa_pkg;

  localparam int ACT_W  = 2;
  localparam int PAIR_W = 12;
  localparam int ORB_W  = 6;
  localparam int VAL_W  = 48;
  localparam int ACC_W  = 64;
  localparam int MODE_W = 2;

  // operand widths of the shared multiplier (sign-magnitude)
  localparam int XMAG_W = 50;
  localparam int YMAG_W = 48;
  localparam int PROD_W = XMAG_W + YMAG_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD     = 2'd0,
    ACT_INTEGRAL = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  localparam logic [MODE_W-1:0] MODE_UNRESTRICTED = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PERM,
    ST_DRD,
    ST_DWAIT,
    ST_MUL,
    ST_RND,
    ST_UPD
  } state_t;

  // contribution being worked on within one permutation
  typedef enum logic [1:0] {
    TERM_J,
    TERM_KA,
    TERM_KB
  } term_t;

endpackage

[src/fsa_in_if.sv]
interface fsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsa_pkg::ACT_W-1:0]     action;
  logic [fsa_pkg::PAIR_W-1:0]    pair_index;
  logic [fsa_pkg::ORB_W-1:0]     orb_p;
  logic [fsa_pkg::ORB_W-1:0]     orb_q;
  logic [fsa_pkg::ORB_W-1:0]     orb_r;
  logic [fsa_pkg::ORB_W-1:0]     orb_s;
  logic signed [fsa_pkg::VAL_W-1:0] integral_value;
  logic signed [fsa_pkg::VAL_W-1:0] dens_alpha;
  logic signed [fsa_pkg::VAL_W-1:0] dens_beta;

  modport source (output valid, action, pair_index, orb_p, orb_q, orb_r, orb_s,
                  integral_value, dens_alpha, dens_beta, input ready);
  modport sink   (input valid, action, pair_index, orb_p, orb_q, orb_r, orb_s,
                  integral_value, dens_alpha, dens_beta, output ready);
endinterface

[src/fsa_out_if.sv]
interface fsa_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fsa_pkg::ACC_W-1:0] fock_alpha;
  logic signed [fsa_pkg::ACC_W-1:0] fock_beta;

  modport source (output valid, fock_alpha, fock_beta, input ready);
  modport sink   (input valid, fock_alpha, fock_beta, output ready);
endinterface

[src/fsa_cfg_if.sv]
interface fsa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fsa_pkg::MODE_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[src/fsa_ram.sv]
module fsa_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 2080,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // single port, read-before-write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[src/fsa_mul.sv]
module fsa_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fsa_pkg::XMAG_W-1:0]  x_mag,
  input  logic [fsa_pkg::YMAG_W-1:0]  y_mag,
  output logic                        done,
  output logic [fsa_pkg::PROD_W-1:0]  product
);
  import fsa_pkg::*;

  localparam int XH = XMAG_W / 2;
  localparam int YH = YMAG_W / 2;

  logic [XMAG_W-1:0] x_r;
  logic [YMAG_W-1:0] y_r;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [1:0]        step_r;
  logic              busy_r;
  logic              done_r;
  logic [XH-1:0]     x_part;
  logic [YH-1:0]     y_part;
  logic [XH+YH-1:0]  pp;
  logic [PROD_W-1:0] pp_shift;

  // one 25x24 partial product per cycle, four partial products per product
  always_comb begin
    x_part   = step_r[1] ? x_r[XMAG_W-1:XH] : x_r[XH-1:0];
    y_part   = step_r[0] ? y_r[YMAG_W-1:YH] : y_r[YH-1:0];
    pp       = XH'(x_part) * YH'(y_part);
    pp_shift = PROD_W'(pp) << ((step_r[1] ? XH : 0) + (step_r[0] ? YH : 0));
    acc_nxt  = acc_r + pp_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x_mag;
      y_r   <= y_mag;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

[src/fock_symmetric_accumulator_core.sv]
// Fock matrix builder over packed lower-triangle stores. A load item writes
// both densities at an in-range pair and zeroes both Fock entries there; a
// read item waits in its own state until the result register is free; an
// integral item walks its up to eight distinct index permutations and runs
// each Coulomb or exchange contribution through one shared multiplier as
// density read and wait, the multiplier's four partial products and its done
// flag, round, and a Fock read-modify-write over the single store port, for
// up to 24 contributions per integral. After reset the block sweeps the Fock
// stores to zero, one pair per cycle over all ORBITALS*(ORBITALS+1)/2 pairs
// (2080 at the default), and accepts no item until done.
module fock_symmetric_accumulator_core #(
  parameter int ORBITALS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  fsa_in_if.sink     in_ch,
  fsa_out_if.source  out_ch,
  fsa_cfg_if.sink    cfg_ch
);
  import fsa_pkg::*;

  localparam int PAIRS = ORBITALS * (ORBITALS + 1) / 2;
  localparam int AW    = $clog2(PAIRS);

  // packed pair index of (i,j)
  function automatic logic [AW-1:0] tri_idx(input logic [ORB_W-1:0] i,
                                            input logic [ORB_W-1:0] j);
    logic [ORB_W-1:0]   hi;
    logic [ORB_W-1:0]   lo;
    logic [2*ORB_W:0]   t;
    hi = (i > j) ? i : j;
    lo = (i > j) ? j : i;
    t  = ((((2*ORB_W+1)'(hi)) * ((2*ORB_W+1)'(hi) + 1'b1)) >> 1) + (2*ORB_W+1)'(lo);
    return AW'(t);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [ACC_W+1:0] d);
    logic signed [ACC_W+1:0] s;
    s = (ACC_W+2)'(acc) + d;
    if (s[ACC_W+1:ACC_W-1] == 3'b000 || s[ACC_W+1:ACC_W-1] == 3'b111) begin
      return s[ACC_W-1:0];
    end else if (s[ACC_W+1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  state_t state_r, state_nxt;
  term_t  term_r, term_nxt;
  logic [2:0]         perm_r, perm_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic [MODE_W-1:0]  mode_r;
  logic               unr;

  logic [ORB_W-1:0]   p_r, q_r, r_r, s_r;
  logic signed [VAL_W-1:0] v_r;
  logic [PAIR_W-1:0]  pair_r;
  logic               pair_ok_r;

  logic               out_valid_r;
  logic signed [ACC_W-1:0] out_fa_r, out_fb_r;

  // permutation under work
  logic [ORB_W-1:0]   pa, pb, pc, pd;
  logic [ORB_W-1:0]   t_a [8];
  logic [ORB_W-1:0]   t_b [8];
  logic [ORB_W-1:0]   t_c [8];
  logic [ORB_W-1:0]   t_d [8];
  logic [7:0]         dup;
  logic               need_j, need_k;

  // stores
  logic               d_we, f_we_a, f_we_b;
  logic [AW-1:0]      d_addr, f_addr;
  logic [VAL_W-1:0]   da_q, db_q;
  logic [ACC_W-1:0]   fa_q, fb_q, fa_wd, fb_wd;

  // multiplier and rounding
  logic               mul_start, mul_done;
  logic [XMAG_W-1:0]  x_mag;
  logic [YMAG_W-1:0]  y_mag;
  logic [PROD_W-1:0]  product;
  logic signed [XMAG_W-1:0] x_op;
  logic               neg_r, sh39_r;
  logic signed [ACC_W+1:0] delta_r, delta_nxt;
  logic [PROD_W-1:0]  biased;
  logic [PROD_W-1:0]  mag_sh;

  logic in_ok, pair_in_ok, orb_ok, out_free;

  assign unr = (mode_r >= MODE_UNRESTRICTED);

  // eight index permutations and duplicate detection
  always_comb begin
    t_a[0] = p_r; t_b[0] = q_r; t_c[0] = r_r; t_d[0] = s_r;
    t_a[1] = q_r; t_b[1] = p_r; t_c[1] = r_r; t_d[1] = s_r;
    t_a[2] = p_r; t_b[2] = q_r; t_c[2] = s_r; t_d[2] = r_r;
    t_a[3] = q_r; t_b[3] = p_r; t_c[3] = s_r; t_d[3] = r_r;
    t_a[4] = r_r; t_b[4] = s_r; t_c[4] = p_r; t_d[4] = q_r;
    t_a[5] = r_r; t_b[5] = s_r; t_c[5] = q_r; t_d[5] = p_r;
    t_a[6] = s_r; t_b[6] = r_r; t_c[6] = p_r; t_d[6] = q_r;
    t_a[7] = s_r; t_b[7] = r_r; t_c[7] = q_r; t_d[7] = p_r;
    for (int i = 0; i < 8; i++) begin
      dup[i] = 1'b0;
      for (int k = 0; k < i; k++) begin
        if (t_a[k] == t_a[i] && t_b[k] == t_b[i] && t_c[k] == t_c[i] && t_d[k] == t_d[i]) begin
          dup[i] = 1'b1;
        end
      end
    end
    pa = t_a[perm_r];
    pb = t_b[perm_r];
    pc = t_c[perm_r];
    pd = t_d[perm_r];
    need_j = (perm_r == 3'd0) || (pc >= pd);
    need_k = (pb >= pc);
  end

  assign out_free   = !out_valid_r || out_ch.ready;
  assign pair_in_ok = 32'(in_ch.pair_index) < PAIRS;
  assign orb_ok     = 32'(in_ch.orb_p) < ORBITALS && 32'(in_ch.orb_q) < ORBITALS &&
                      32'(in_ch.orb_r) < ORBITALS && 32'(in_ch.orb_s) < ORBITALS;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_ok       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // multiplier operands: Coulomb uses (Da+Db) or Da, exchange Da or Db
  always_comb begin
    if (term_r == TERM_J) begin
      x_op = unr ? (XMAG_W'($signed(da_q)) + XMAG_W'($signed(db_q)))
                 : XMAG_W'($signed(da_q));
    end else if (term_r == TERM_KA) begin
      x_op = XMAG_W'($signed(da_q));
    end else begin
      x_op = XMAG_W'($signed(db_q));
    end
    x_mag = x_op[XMAG_W-1] ? XMAG_W'(-x_op) : XMAG_W'(x_op);
    y_mag = v_r[VAL_W-1] ? YMAG_W'(-v_r) : YMAG_W'(v_r);
  end

  // floor rounding of the signed product, sign applied per term kind
  always_comb begin
    biased = product;
    if (neg_r) begin
      biased = product + (sh39_r ? PROD_W'((64'd1 << 39) - 64'd1)
                                 : PROD_W'((64'd1 << 40) - 64'd1));
    end
    mag_sh = sh39_r ? (biased >> 39) : (biased >> 40);
    if (neg_r ^ (term_r != TERM_J)) begin
      delta_nxt = -($signed((ACC_W+2)'(mag_sh)));
    end else begin
      delta_nxt = $signed((ACC_W+2)'(mag_sh));
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    perm_nxt  = perm_r;
    mul_start = 1'b0;
    d_we      = 1'b0;
    f_we_a    = 1'b0;
    f_we_b    = 1'b0;
    fa_wd     = '0;
    fb_wd     = '0;
    d_addr    = (term_r == TERM_J) ? tri_idx(pa, pb) : tri_idx(pa, pd);
    f_addr    = (term_r == TERM_J) ? tri_idx(pc, pd) : tri_idx(pb, pc);
    case (state_r)
      ST_CLEAR: begin
        f_addr = clr_cnt_r;
        f_we_a = 1'b1;
        f_we_b = 1'b1;
        if (32'(clr_cnt_r) == PAIRS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        d_addr = AW'(in_ch.pair_index);
        f_addr = AW'(in_ch.pair_index);
        if (in_ok) begin
          case (in_ch.action)
            ACT_LOAD: begin
              d_we   = pair_in_ok;
              f_we_a = pair_in_ok;
              f_we_b = pair_in_ok;
            end
            ACT_INTEGRAL: begin
              if (orb_ok) begin
                perm_nxt  = 3'd0;
                state_nxt = ST_PERM;
              end
            end
            ACT_READ: begin
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // keep the read address so the store output holds while the result waits
        f_addr = AW'(pair_r);
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PERM: begin
        if (!dup[perm_r] && need_j) begin
          term_nxt  = TERM_J;
          state_nxt = ST_DRD;
        end else if (!dup[perm_r] && need_k) begin
          term_nxt  = TERM_KA;
          state_nxt = ST_DRD;
        end else if (perm_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end else begin
          perm_nxt = perm_r + 3'd1;
        end
      end
      ST_DRD: begin
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        fa_wd  = sat_add($signed(fa_q), delta_r);
        fb_wd  = sat_add($signed(fb_q), delta_r);
        f_we_a = (term_r == TERM_J) || (term_r == TERM_KA);
        f_we_b = (term_r == TERM_J && unr) || (term_r == TERM_KB);
        if (term_r == TERM_J && need_k) begin
          term_nxt  = TERM_KA;
          state_nxt = ST_DRD;
        end else if (term_r == TERM_KA && unr) begin
          term_nxt  = TERM_KB;
          state_nxt = ST_DRD;
        end else if (perm_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end else begin
          perm_nxt  = perm_r + 3'd1;
          state_nxt = ST_PERM;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      term_r      <= TERM_J;
      perm_r      <= '0;
      clr_cnt_r   <= '0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      perm_r  <= perm_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.data;
      end
      if (state_r == ST_READ && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ok) begin
      p_r       <= in_ch.orb_p;
      q_r       <= in_ch.orb_q;
      r_r       <= in_ch.orb_r;
      s_r       <= in_ch.orb_s;
      v_r       <= in_ch.integral_value;
      pair_r    <= in_ch.pair_index;
      pair_ok_r <= pair_in_ok;
    end
    if (state_r == ST_DWAIT) begin
      neg_r  <= x_op[XMAG_W-1] ^ v_r[VAL_W-1];
      sh39_r <= (term_r == TERM_J) && !unr;
    end
    if (state_r == ST_RND) begin
      delta_r <= delta_nxt;
    end
    if (state_r == ST_READ && out_free) begin
      out_fa_r <= pair_ok_r ? $signed(fa_q) : '0;
      out_fb_r <= pair_ok_r ? $signed(fb_q) : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fock_alpha = out_fa_r;
  assign out_ch.fock_beta  = out_fb_r;

  fsa_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .x_mag   (x_mag),
    .y_mag   (y_mag),
    .done    (mul_done),
    .product (product)
  );

  fsa_ram #(.W(VAL_W), .DEPTH(PAIRS), .AW(AW)) u_dens_a (
    .clk (clk), .we (d_we), .addr (d_addr), .wdata (in_ch.dens_alpha), .rdata (da_q)
  );

  fsa_ram #(.W(VAL_W), .DEPTH(PAIRS), .AW(AW)) u_dens_b (
    .clk (clk), .we (d_we), .addr (d_addr), .wdata (in_ch.dens_beta), .rdata (db_q)
  );

  fsa_ram #(.W(ACC_W), .DEPTH(PAIRS), .AW(AW)) u_fock_a (
    .clk (clk), .we (f_we_a), .addr (f_addr), .wdata (fa_wd), .rdata (fa_q)
  );

  fsa_ram #(.W(ACC_W), .DEPTH(PAIRS), .AW(AW)) u_fock_b (
    .clk (clk), .we (f_we_b), .addr (f_addr), .wdata (fb_wd), .rdata (fb_q)
  );

endmodule
